// File: src/bpff_pkg.sv
// ----------------------------------------------------------------------------
// bpff_pkg
// Shared types and constants of the first-fit pool allocator: default pool
// size, field widths, controller states and the command and status groups
// between controller and datapath.
// ----------------------------------------------------------------------------
package bpff_pkg;

   localparam int DEF_POOL_UNITS = 4096;
   localparam int BYTE_W         = 16;
   localparam int NEED_W         = 13;
   localparam int UNIT_SHIFT     = 4;
   localparam int ROUND_ADD      = 15;
   localparam int OFFSET_UNITS_W = BYTE_W - UNIT_SHIFT;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK_RD,
      S_WALK_CHK,
      S_UNLINK,
      S_FREE_RD,
      S_FREE_WR,
      S_POST
   } state_type;

   typedef struct packed {
      logic load_req;
      logic mem_rd_cur;
      logic walk_advance;
      logic wr_prev_link;
      logic set_head_next;
      logic wr_cur_end;
      logic res_reuse;
      logic do_bump;
      logic mem_rd_free;
      logic do_free_link;
      logic res_fail;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic req_is_free;
      logic walk_live;
      logic fits;
      logic prev_valid;
      logic free_ok;
      logic rsp_free;
   } status_type;

endpackage

// File: src/bpff_ram.sv
// ----------------------------------------------------------------------------
// bpff_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module bpff_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/bpff_ctrl.sv
// ----------------------------------------------------------------------------
// bpff_ctrl
// Controller of the allocator: sequences the free-list walk, the unlink
// writes, the bump carve, the free push and the hand-off to the output
// register.
// ----------------------------------------------------------------------------
module bpff_ctrl import bpff_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = status.req_is_free ? S_FREE_RD : S_WALK_RD;
            end
         end
         S_WALK_RD: begin
            if (status.walk_live) begin
               cmd.mem_rd_cur = 1'b1;
               state_in       = S_WALK_CHK;
            end else begin
               cmd.do_bump = 1'b1;
               state_in    = S_POST;
            end
         end
         S_WALK_CHK: begin
            if (status.fits) begin
               if (status.prev_valid) begin
                  cmd.wr_prev_link = 1'b1;
                  state_in         = S_UNLINK;
               end else begin
                  cmd.set_head_next = 1'b1;
                  cmd.wr_cur_end    = 1'b1;
                  cmd.res_reuse     = 1'b1;
                  state_in          = S_POST;
               end
            end else begin
               cmd.walk_advance = 1'b1;
               state_in         = S_WALK_RD;
            end
         end
         S_UNLINK: begin
            cmd.wr_cur_end = 1'b1;
            cmd.res_reuse  = 1'b1;
            state_in       = S_POST;
         end
         S_FREE_RD: begin
            if (status.free_ok) begin
               cmd.mem_rd_free = 1'b1;
               state_in        = S_FREE_WR;
            end else begin
               cmd.res_fail = 1'b1;
               state_in     = S_POST;
            end
         end
         S_FREE_WR: begin
            cmd.do_free_link = 1'b1;
            state_in         = S_POST;
         end
         S_POST: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: src/bpff_datapath.sv
// ----------------------------------------------------------------------------
// bpff_datapath
// Datapath of the allocator: request registers, bump pointer, free-list head,
// walk pointers, header RAM, staged result and output register.
// ----------------------------------------------------------------------------
module bpff_datapath import bpff_pkg::*; #(
   parameter int POOL_UNITS = DEF_POOL_UNITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_op,
   input  logic [BYTE_W-1:0] req_req_bytes,
   input  logic [BYTE_W-1:0] req_free_addr,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_ok,
   output logic [BYTE_W-1:0] rsp_payload_addr,
   output logic              rsp_reused,
   input  cmd_type           cmd,
   output status_type        status
);

   localparam int UNIT_W = $clog2(POOL_UNITS + 1);
   localparam int ADDR_W = $clog2(POOL_UNITS);
   localparam int CW     = (UNIT_W > NEED_W) ? UNIT_W : NEED_W;
   localparam int EXT_W  = ((UNIT_W + 1) > OFFSET_UNITS_W) ? (UNIT_W + 1) : OFFSET_UNITS_W;
   localparam int ENT_W  = 2 * UNIT_W;
   localparam logic [UNIT_W-1:0] LIST_END = UNIT_W'(POOL_UNITS);
   localparam logic [CW-1:0]     POOL_CW  = CW'(POOL_UNITS);

   logic [NEED_W-1:0]         need_ff;
   logic [OFFSET_UNITS_W-1:0] free_unit_ff;
   logic                      free_fmt_ff;
   logic [UNIT_W-1:0]         bump_ff;
   logic [UNIT_W-1:0]         head_ff;
   logic [UNIT_W-1:0]         cur_ff;
   logic [UNIT_W-1:0]         prev_ff;
   logic [UNIT_W-1:0]         prev_total_ff;
   logic [UNIT_W-1:0]         steps_ff;
   logic                      res_ok_ff;
   logic [BYTE_W-1:0]         res_addr_ff;
   logic                      res_reused_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_ok_ff;
   logic [BYTE_W-1:0]         rsp_addr_ff;
   logic                      rsp_reused_ff;

   logic [BYTE_W:0]           round_sum;
   logic [NEED_W-1:0]         need_in;
   logic [OFFSET_UNITS_W-1:0] free_unit_in;
   logic [ENT_W-1:0]          rd_data;
   logic [UNIT_W-1:0]         rd_total;
   logic [UNIT_W-1:0]         rd_next;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic [ENT_W-1:0]          wr_data;
   logic                      rd_en;
   logic [ADDR_W-1:0]         rd_addr;
   logic [CW-1:0]             need_cw;
   logic [CW-1:0]             bump_cw;
   logic                      bump_fit;
   logic                      free_ok;
   logic [BYTE_W-1:0]         cur_addr;
   logic [BYTE_W-1:0]         bump_addr;
   logic [EXT_W-1:0]          cur_plus;
   logic [EXT_W-1:0]          bump_plus;

   assign round_sum    = {1'b0, req_req_bytes} + (BYTE_W + 1)'(ROUND_ADD);
   assign need_in      = round_sum[BYTE_W:UNIT_SHIFT] + NEED_W'(1);
   assign free_unit_in = req_free_addr[BYTE_W-1:UNIT_SHIFT] - OFFSET_UNITS_W'(1);

   assign rd_total = rd_data[ENT_W-1:UNIT_W];
   assign rd_next  = rd_data[UNIT_W-1:0];

   assign need_cw  = CW'(need_ff);
   assign bump_cw  = CW'(bump_ff);
   assign bump_fit = (bump_cw <= POOL_CW) && (need_cw <= (POOL_CW - bump_cw));
   assign free_ok  = free_fmt_ff && (CW'(free_unit_ff) < bump_cw)
                     && (CW'(free_unit_ff) < POOL_CW);

   assign cur_plus  = EXT_W'(cur_ff) + EXT_W'(1);
   assign bump_plus = EXT_W'(bump_ff) + EXT_W'(1);
   assign cur_addr  = {cur_plus[OFFSET_UNITS_W-1:0], {UNIT_SHIFT{1'b0}}};
   assign bump_addr = {bump_plus[OFFSET_UNITS_W-1:0], {UNIT_SHIFT{1'b0}}};

   assign status.req_is_free = (req_op == OP_FREE);
   assign status.walk_live   = (cur_ff < LIST_END) && (steps_ff < LIST_END);
   assign status.fits        = (CW'(rd_total) >= need_cw);
   assign status.prev_valid  = (prev_ff < LIST_END);
   assign status.free_ok     = free_ok;
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rd_en   = cmd.mem_rd_cur || cmd.mem_rd_free;
      rd_addr = cmd.mem_rd_free ? ADDR_W'(free_unit_ff) : cur_ff[ADDR_W-1:0];
      wr_en   = 1'b0;
      wr_addr = cur_ff[ADDR_W-1:0];
      wr_data = {rd_total, LIST_END};
      if (cmd.wr_prev_link) begin
         wr_en   = 1'b1;
         wr_addr = prev_ff[ADDR_W-1:0];
         wr_data = {prev_total_ff, rd_next};
      end else if (cmd.wr_cur_end) begin
         wr_en   = 1'b1;
         wr_addr = cur_ff[ADDR_W-1:0];
         wr_data = {rd_total, LIST_END};
      end else if (cmd.do_bump && bump_fit) begin
         wr_en   = 1'b1;
         wr_addr = bump_ff[ADDR_W-1:0];
         wr_data = {need_cw[UNIT_W-1:0], LIST_END};
      end else if (cmd.do_free_link) begin
         wr_en   = 1'b1;
         wr_addr = ADDR_W'(free_unit_ff);
         wr_data = {rd_total, head_ff};
      end
   end

   bpff_ram #(
      .WIDTH(ENT_W),
      .DEPTH(POOL_UNITS)
   ) u_hdr_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bump_ff      <= '0;
         head_ff      <= LIST_END;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.set_head_next) begin
            head_ff <= rd_next;
         end else if (cmd.do_free_link) begin
            head_ff <= UNIT_W'(free_unit_ff);
         end
         if (cmd.do_bump && bump_fit) begin
            bump_ff <= bump_ff + need_cw[UNIT_W-1:0];
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         need_ff      <= need_in;
         free_unit_ff <= free_unit_in;
         free_fmt_ff  <= (req_free_addr != '0)
                         && (req_free_addr[UNIT_SHIFT-1:0] == '0);
         cur_ff       <= head_ff;
         prev_ff      <= LIST_END;
         steps_ff     <= '0;
      end else if (cmd.walk_advance) begin
         prev_ff       <= cur_ff;
         prev_total_ff <= rd_total;
         cur_ff        <= rd_next;
         steps_ff      <= steps_ff + UNIT_W'(1);
      end
      if (cmd.res_reuse) begin
         res_ok_ff     <= 1'b1;
         res_addr_ff   <= cur_addr;
         res_reused_ff <= 1'b1;
      end else if (cmd.do_bump) begin
         res_ok_ff     <= bump_fit;
         res_addr_ff   <= bump_fit ? bump_addr : '0;
         res_reused_ff <= 1'b0;
      end else if (cmd.do_free_link) begin
         res_ok_ff     <= 1'b1;
         res_addr_ff   <= '0;
         res_reused_ff <= 1'b0;
      end else if (cmd.res_fail) begin
         res_ok_ff     <= 1'b0;
         res_addr_ff   <= '0;
         res_reused_ff <= 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_ok_ff     <= res_ok_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_reused_ff <= res_reused_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_payload_addr = rsp_addr_ff;
   assign rsp_reused       = rsp_reused_ff;

endmodule

// File: src/bump_pool_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// bump_pool_first_fit_allocator
// A free reads the freed block's header and pushes it as the new list head; a
// rejected free goes straight to the result. An allocate checks free-list
// entries in turn and reuses the first that fits (with an extra unlink step
// if it is not the head), else carves from the bump pointer. A result is valid
// as the next item can be accepted; one left waiting holds the next item back.
// Reset empties the free list and zeroes the bump pointer; no clearing pass.
// ----------------------------------------------------------------------------
module bump_pool_first_fit_allocator import bpff_pkg::*; #(
   parameter int POOL_UNITS = DEF_POOL_UNITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [BYTE_W-1:0] req_req_bytes,
   input  logic [BYTE_W-1:0] req_free_addr,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_ok,
   output logic [BYTE_W-1:0] rsp_payload_addr,
   output logic              rsp_reused
);

   cmd_type    cmd;
   status_type status;

   bpff_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   bpff_datapath #(
      .POOL_UNITS(POOL_UNITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_op),
      .req_req_bytes   (req_req_bytes),
      .req_free_addr   (req_free_addr),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_payload_addr(rsp_payload_addr),
      .rsp_reused      (rsp_reused),
      .cmd             (cmd),
      .status          (status)
   );

endmodule
